// ===== src/ssmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment multiplexed display driver package
// Shared types, register indexes, decimal conversion constants and the
// segment glyph table.
// ----------------------------------------------------------------------------
package ssmd_pkg;

    // Request kinds.
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_VALUE  = 2'd1,
        MODE_FORMAT = 2'd2
    } t_mode;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCAN_BY_SEGMENT = 2'd0;
    localparam logic [1:0] CFG_SEG_ACTIVE_HIGH = 2'd1;
    localparam logic [1:0] CFG_DIG_ACTIVE_HIGH = 2'd2;
    localparam logic [1:0] CFG_NUM_DIGITS      = 2'd3;

    localparam int CFG_DATA_W = 4;

    // Segment layout: a is bit 0, g is bit 6, the point is bit 7.
    localparam logic [7:0] POINT_BIT     = 8'h80;
    localparam logic [7:0] BLANK_PATTERN = 8'h00;
    localparam logic [3:0] MAX_AMOUNT    = 4'd8;

    // Reciprocal multipliers: value / 10^k == (value * MUL) >> SHIFT for
    // every 16-bit value.
    localparam logic [32:0] DIV10_MUL    = 33'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam logic [32:0] DIV100_MUL   = 33'd83887;
    localparam int          DIV100_SHIFT = 23;
    localparam logic [32:0] DIV1K_MUL    = 33'd67109;
    localparam int          DIV1K_SHIFT  = 26;
    localparam logic [32:0] DIV10K_MUL   = 33'd107375;
    localparam int          DIV10K_SHIFT = 30;

    // Quotients of the value by 10, 100, 1000 and 10000.
    typedef struct packed {
        logic [12:0] q1;
        logic [9:0]  q2;
        logic [6:0]  q3;
        logic [2:0]  q4;
    } t_quot;

    function automatic logic [7:0] f_glyph(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            default: pattern = BLANK_PATTERN;
        endcase
        return pattern;
    endfunction

endpackage

// ===== src/ssmd_decimal.sv =====
// ----------------------------------------------------------------------------
// Decimal quotient unit
// Divides a 16-bit value by 10, 100, 1000 and 10000 with independent
// reciprocal multiplications, one per power of ten.
// ----------------------------------------------------------------------------
module ssmd_decimal (
    input  logic [15:0]         i_value,
    output ssmd_pkg::t_quot     o_quot
);
    import ssmd_pkg::*;

    logic [32:0] w_p1;
    logic [32:0] w_p2;
    logic [32:0] w_p3;
    logic [32:0] w_p4;

    assign w_p1 = 33'(i_value) * DIV10_MUL;
    assign w_p2 = 33'(i_value) * DIV100_MUL;
    assign w_p3 = 33'(i_value) * DIV1K_MUL;
    assign w_p4 = 33'(i_value) * DIV10K_MUL;

    assign o_quot.q1 = w_p1[DIV10_SHIFT  +: 13];
    assign o_quot.q2 = w_p2[DIV100_SHIFT +: 10];
    assign o_quot.q3 = w_p3[DIV1K_SHIFT  +: 7];
    assign o_quot.q4 = w_p4[DIV10K_SHIFT +: 3];

endmodule

// ===== src/seven_segment_mux_driver_core.sv =====
// ----------------------------------------------------------------------------
// Seven-segment multiplexed display driver core
// Per-digit segment buffer with decimal write, formatted write and a
// digit-wise or segment-wise multiplex scan with per-group line polarity.
// ----------------------------------------------------------------------------
// The core takes one request per clock while the consumer keeps up and
// returns exactly one response per request. The request register holds
// the request with the quotients of its value by 10, 100, 1000 and 10000
// (four independent reciprocal multipliers); the buffer stage then updates
// the digit buffer or the scan and registers the line levels. Either stage
// holds when the consumer stalls, and a new request is taken in the same
// cycle that a finished response leaves, so the sustained rate is one
// request per cycle when unstalled. A tick request advances the scan
// and returns the new line levels; a show-value or formatted request rewrites
// the buffer and returns the current line levels unchanged. Configuration
// writes take effect at once and are meant to be made while no request is in
// flight.
module seven_segment_mux_driver_core #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_value,
    input  logic [3:0]  i_comma,
    input  logic [3:0]  i_position,
    input  logic [3:0]  i_amount,
    // Response channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_segment_drive,
    output logic [7:0]  o_digit_drive,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [ssmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssmd_pkg::*;

    // Digit index, fitted-count and scan-slot widths. The slot must hold
    // both a segment number (0..7) and a digit number.
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int SW = (IW > 3) ? IW : 3;

    // ---------------- Configuration registers ----------------
    logic       r_scan_by_segment;
    logic       r_seg_active_high;
    logic       r_dig_active_high;
    logic [3:0] r_num_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_by_segment <= 1'b0;
            r_seg_active_high <= 1'b1;
            r_dig_active_high <= 1'b1;
            r_num_digits      <= 4'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCAN_BY_SEGMENT: r_scan_by_segment <= i_cfg_data[0];
                CFG_SEG_ACTIVE_HIGH: r_seg_active_high <= i_cfg_data[0];
                CFG_DIG_ACTIVE_HIGH: r_dig_active_high <= i_cfg_data[0];
                CFG_NUM_DIGITS:      r_num_digits      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // The number of fitted digits: zero acts as one, and anything above the
    // buffer depth saturates to it.
    logic [CW-1:0] w_fit;

    always_comb begin
        if (r_num_digits == 4'd0) begin
            w_fit = CW'(1);
        end else if (int'(r_num_digits) > MAX_DIGITS) begin
            w_fit = CW'(MAX_DIGITS);
        end else begin
            w_fit = CW'(r_num_digits);
        end
    end

    // ---------------- Request register ----------------
    // The decimal quotients are computed on the way in so that the buffer
    // update stage only has to subtract and look up glyphs.
    t_quot w_quot;

    ssmd_decimal u_decimal (
        .i_value (i_value),
        .o_quot  (w_quot)
    );

    logic        r_req_valid;
    logic [1:0]  r_mode;
    logic [15:0] r_value;
    logic [3:0]  r_comma;
    logic [3:0]  r_position;
    logic [3:0]  r_amount;
    t_quot       r_quot;

    logic        r_out_valid;
    logic        w_advance;

    // The request in the register moves on when the response register is
    // empty or is being emptied in this cycle.
    assign w_advance = r_req_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_req_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_ready) begin
            r_req_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode     <= i_mode;
            r_value    <= i_value;
            r_comma    <= i_comma;
            r_position <= i_position;
            r_amount   <= i_amount;
            r_quot     <= w_quot;
        end
    end

    // ---------------- Decimal digits ----------------
    // Remainders after division by successive powers of ten. Beyond the
    // fifth digit a 16-bit value has nothing left.
    logic [15:0] w_qv [0:7];
    logic [3:0]  w_dv [0:7];
    logic        w_qnz [0:7];

    always_comb begin
        w_qv[0] = r_value;
        w_qv[1] = 16'(r_quot.q1);
        w_qv[2] = 16'(r_quot.q2);
        w_qv[3] = 16'(r_quot.q3);
        w_qv[4] = 16'(r_quot.q4);
        w_qv[5] = 16'd0;
        w_qv[6] = 16'd0;
        w_qv[7] = 16'd0;
        for (int k = 0; k < 8; k++) begin
            if (k < 7) begin
                w_dv[k] = 4'(w_qv[k] - (w_qv[k + 1] << 3) - (w_qv[k + 1] << 1));
            end else begin
                w_dv[k] = 4'd0;
            end
            w_qnz[k] = (w_qv[k] != 16'd0);
        end
    end

    // ---------------- Digit buffer update ----------------
    logic [7:0] r_patterns [0:MAX_DIGITS-1];
    logic [7:0] n_patterns [0:MAX_DIGITS-1];

    always_comb begin
        int fit_i;
        int comma_i;
        int pos_i;
        int amt_i;
        int iter;
        logic point_ok;
        fit_i    = int'(w_fit);
        comma_i  = int'(r_comma);
        pos_i    = int'(r_position);
        amt_i    = (r_amount > MAX_AMOUNT) ? int'(MAX_AMOUNT) : int'(r_amount);
        point_ok = (comma_i != 0) && (comma_i <= fit_i);
        iter     = 0;
        for (int j = 0; j < MAX_DIGITS; j++) begin
            n_patterns[j] = r_patterns[j];
            case (r_mode)
                MODE_VALUE: begin
                    // Units land in digit 0; leading zeros blank except up to
                    // the comma position.
                    if (j < fit_i) begin
                        if (j == 0 || (j < 8 && w_qnz[3'(j)]) || j <= comma_i) begin
                            n_patterns[j] = (j < 8) ? f_glyph(w_dv[3'(j)])
                                                    : f_glyph(4'd0);
                        end else begin
                            n_patterns[j] = BLANK_PATTERN;
                        end
                    end
                    if (point_ok && j == comma_i - 1) begin
                        n_patterns[j] = n_patterns[j] | POINT_BIT;
                    end
                end
                MODE_FORMAT: begin
                    // The run starts at the 1-based position and stops at the
                    // last fitted digit.
                    iter = j + 1 - pos_i;
                    if (pos_i != 0 && pos_i <= fit_i && j < fit_i &&
                        iter >= 0 && iter < amt_i) begin
                        if (iter == 0 || w_qnz[3'(iter)] || j + 1 <= comma_i) begin
                            n_patterns[j] = f_glyph(w_dv[3'(iter)]);
                        end else begin
                            n_patterns[j] = BLANK_PATTERN;
                        end
                    end
                    if (point_ok && j == comma_i - 1) begin
                        n_patterns[j] = n_patterns[j] | POINT_BIT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- Scan ----------------
    logic [SW-1:0] r_scan_slot;
    logic [7:0]    r_seg_lines;
    logic [7:0]    r_dig_lines;
    logic [SW-1:0] n_scan_slot;
    logic [7:0]    n_seg_lines;
    logic [7:0]    n_dig_lines;

    always_comb begin
        logic [SW-1:0] slot;
        logic [2:0]    seg_sel;
        slot        = r_scan_slot;
        seg_sel     = r_scan_slot[2:0];
        n_scan_slot = r_scan_slot;
        n_seg_lines = r_seg_lines;
        n_dig_lines = r_dig_lines;
        if (t_mode'(r_mode) == MODE_TICK) begin
            if (r_scan_by_segment) begin
                // One segment lit; every fitted digit showing it is selected.
                n_seg_lines = 8'(1) << seg_sel;
                for (int b = 0; b < 8; b++) begin
                    if (b < MAX_DIGITS) begin
                        n_dig_lines[b] = (b < int'(w_fit)) &&
                                         r_patterns[IW'(b)][seg_sel];
                    end else begin
                        n_dig_lines[b] = 1'b0;
                    end
                end
                n_scan_slot = SW'(3'(seg_sel + 3'd1));
            end else begin
                // One digit lit; a slot left over from a larger count or from
                // the segment scan restarts at digit 0.
                if (int'(slot) >= int'(w_fit)) begin
                    slot = '0;
                end
                n_seg_lines = r_patterns[slot[IW-1:0]];
                for (int b = 0; b < 8; b++) begin
                    n_dig_lines[b] = (int'(slot) == b);
                end
                if (int'(slot) + 1 >= int'(w_fit)) begin
                    n_scan_slot = '0;
                end else begin
                    n_scan_slot = SW'(slot + SW'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_slot <= '0;
            r_seg_lines <= 8'h00;
            r_dig_lines <= 8'h00;
            for (int j = 0; j < MAX_DIGITS; j++) begin
                r_patterns[j] <= BLANK_PATTERN;
            end
        end else if (w_advance) begin
            r_scan_slot <= n_scan_slot;
            r_seg_lines <= n_seg_lines;
            r_dig_lines <= n_dig_lines;
            for (int j = 0; j < MAX_DIGITS; j++) begin
                r_patterns[j] <= n_patterns[j];
            end
        end
    end

    // ---------------- Response register ----------------
    // The lines hold lit masks; polarity is applied on the way out.
    logic [7:0] r_segment_drive;
    logic [7:0] r_digit_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_segment_drive <= r_seg_active_high ? n_seg_lines : ~n_seg_lines;
            r_digit_drive   <= r_dig_active_high ? n_dig_lines : ~n_dig_lines;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_drive = r_segment_drive;
    assign o_digit_drive   = r_digit_drive;

endmodule

// ===== src/ssmd_checker.sv =====
// ----------------------------------------------------------------------------
// Seven-segment display driver port checker
// Watches the request and response ports of the core over time.
// ----------------------------------------------------------------------------
module ssmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_segment_drive,
    input logic [7:0] o_digit_drive
);

    // A stalled response stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("response withdrawn while stalled");

    // A stalled response keeps its line levels.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_segment_drive) && $stable(o_digit_drive))
        else $error("response payload changed while stalled");

    // With no response pending the core always takes a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused with the response side empty");

    // Every accepted request is followed by a valid response once it has passed the request and response registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##2 o_valid)
        else $error("accepted request produced no response");

endmodule

bind seven_segment_mux_driver_core ssmd_checker u_ssmd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_segment_drive (o_segment_drive),
    .o_digit_drive   (o_digit_drive)
);

// ===== tb/seven_segment_mux_driver_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment multiplexed display driver core testbench
// Feeds tick, show-value and formatted requests through the request channel
// and checks every response against a cycle-free model of the digit buffer,
// the scan position and the line polarity, over several register settings.
// ----------------------------------------------------------------------------
module seven_segment_mux_driver_core_tb;

    import ssmd_pkg::*;

    // Generous bound: ~1550 requests, each with up to the longest sender gap,
    // the longest consumer stall and its pass through the pipeline, taken ten times.
    localparam int CYCLE_LIMIT    = 600000;
    localparam int PHASE_REQUESTS = 190;
    localparam int PHASE_COUNT    = 8;

    // Segment patterns for the decimal digits 0..9, digit d at bits 8d+7:8d.
    localparam logic [79:0] GLYPH_ROM = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct {
        t_mode       mode;
        logic [15:0] value;
        logic [3:0]  comma;
        logic [3:0]  position;
        logic [3:0]  amount;
    } t_request;

    typedef struct {
        logic [7:0] segment_drive;
        logic [7:0] digit_drive;
    } t_drive;

    // ------------------------------------------------------------------
    // Signals to and from the block. Every input has a known level at
    // time zero.
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    t_mode                 i_mode      = MODE_TICK;
    logic [15:0]           i_value     = '0;
    logic [3:0]            i_comma     = '0;
    logic [3:0]            i_position  = '0;
    logic [3:0]            i_amount    = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [7:0]            o_segment_drive;
    logic [7:0]            o_digit_drive;
    logic                  i_cfg_we    = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    seven_segment_mux_driver_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .i_comma        (i_comma),
        .i_position     (i_position),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segment_drive(o_segment_drive),
        .o_digit_drive  (o_digit_drive),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Display model: its own copy of the digit buffer, the scan slot, the
    // lit masks and the four registers, all at their reset values.
    // ------------------------------------------------------------------
    logic [7:0] shadow_digits [8] = '{default: 8'h00};
    logic [2:0] shadow_slot     = '0;
    logic [7:0] lit_segments    = '0;
    logic [7:0] lit_digits      = '0;
    logic       cfg_by_segment  = 1'b0;
    logic       cfg_seg_high    = 1'b1;
    logic       cfg_dig_high    = 1'b1;
    logic [3:0] cfg_digit_count = 4'd4;

    t_request pending_requests [$];
    t_drive   expected_drives [$];

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned mismatch_count = 0;
    int unsigned tick_total     = 0;
    int unsigned value_total    = 0;
    int unsigned format_total   = 0;
    int unsigned setting_total  = 1;
    int unsigned cycle_count    = 0;

    // Idle rates in percent, changed between phases; both zero at the end.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;

    t_request bus_request;
    t_drive   oldest_drive;

    function automatic int unsigned fitted_digits();
        int unsigned n;
        n = cfg_digit_count;
        if (n == 0) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    // Applies one accepted request to the model and records the line
    // levels that the block must return for it.
    task automatic advance_display(input t_request r);
        int unsigned n;
        int unsigned v;
        int unsigned pos;
        int unsigned count;
        int unsigned slot;
        int unsigned k;
        logic [7:0]  mask;
        t_drive      drive;
        n = fitted_digits();
        v = r.value;
        case (r.mode)
            MODE_TICK: begin
                if (cfg_by_segment) begin
                    // One segment lit; every fitted digit showing it is selected.
                    mask = 8'h01 << shadow_slot;
                    lit_digits = '0;
                    for (k = 0; k < n; k++) begin
                        if ((shadow_digits[k] & mask) != 8'h00) lit_digits[k] = 1'b1;
                    end
                    lit_segments = mask;
                    shadow_slot = shadow_slot + 3'd1;
                end else begin
                    // A slot left over from a larger count or the other scan
                    // style restarts at digit 0.
                    slot = shadow_slot;
                    if (slot >= n) slot = 0;
                    lit_digits = 8'h01 << slot;
                    lit_segments = shadow_digits[slot];
                    slot++;
                    if (slot >= n) slot = 0;
                    shadow_slot = slot[2:0];
                end
                tick_total++;
            end
            MODE_VALUE: begin
                // Leading zeros go dark except on digit 0 and up to the comma.
                for (k = 0; k < n; k++) begin
                    if (k == 0 || v > 0 || k <= r.comma) begin
                        shadow_digits[k] = GLYPH_ROM[(v % 10) * 8 +: 8];
                    end else begin
                        shadow_digits[k] = BLANK_PATTERN;
                    end
                    v = v / 10;
                end
                value_total++;
            end
            MODE_FORMAT: begin
                // The run stops after the last fitted digit.
                count = (r.amount > MAX_AMOUNT) ? MAX_AMOUNT : r.amount;
                pos = r.position;
                if (pos != 0 && pos <= n) begin
                    for (k = 0; k < count && pos <= n; k++) begin
                        if (k == 0 || v > 0 || pos <= r.comma) begin
                            shadow_digits[pos - 1] = GLYPH_ROM[(v % 10) * 8 +: 8];
                        end else begin
                            shadow_digits[pos - 1] = BLANK_PATTERN;
                        end
                        v = v / 10;
                        pos++;
                    end
                end
                format_total++;
            end
            default: begin
            end
        endcase
        if ((r.mode == MODE_VALUE || r.mode == MODE_FORMAT) && r.comma != 0 && r.comma <= n) begin
            shadow_digits[r.comma - 1] = shadow_digits[r.comma - 1] | POINT_BIT;
        end
        drive.segment_drive = cfg_seg_high ? lit_segments : ~lit_segments;
        drive.digit_drive   = cfg_dig_high ? lit_digits : ~lit_digits;
        expected_drives.push_back(drive);
    endtask

    task automatic queue_request(input t_mode mode, input logic [15:0] value,
                                 input logic [3:0] comma, input logic [3:0] position,
                                 input logic [3:0] amount);
        t_request r;
        r.mode     = mode;
        r.value    = value;
        r.comma    = comma;
        r.position = position;
        r.amount   = amount;
        pending_requests.push_back(r);
        queued_count++;
    endtask

    // Ticks most often so that written patterns reach the lines, with values
    // weighted toward short numbers where the blanking rules matter.
    task automatic queue_random_request();
        int unsigned pick;
        t_mode       mode;
        logic [15:0] value;
        logic [3:0]  comma;
        pick = $urandom_range(99);
        if (pick < 45) mode = MODE_TICK;
        else if (pick < 75) mode = MODE_VALUE;
        else mode = MODE_FORMAT;
        case ($urandom_range(3))
            0: value = 16'($urandom_range(16'hFFFF));
            1: value = 16'($urandom_range(999));
            2: value = 16'($urandom_range(9));
            default: value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        if ($urandom_range(9) < 7) comma = 4'($urandom_range(fitted_digits() + 1));
        else comma = 4'($urandom_range(15));
        queue_request(mode, value, comma, 4'($urandom_range(8)), 4'($urandom_range(8)));
    endtask

    // Blocks until every queued request has had its response checked.
    task automatic wait_for_drain();
        while (checked_count != queued_count) @(posedge i_clk);
    endtask

    // Writes one register at the next edge; only called while nothing is
    // in flight, so the model may take the new value at once.
    task automatic write_register(input logic [1:0] index, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            CFG_SCAN_BY_SEGMENT: cfg_by_segment  = data[0];
            CFG_SEG_ACTIVE_HIGH: cfg_seg_high    = data[0];
            CFG_DIG_ACTIVE_HIGH: cfg_dig_high    = data[0];
            CFG_NUM_DIGITS:      cfg_digit_count = data;
            default: begin
            end
        endcase
    endtask

    task automatic apply_setting(input logic by_segment, input logic seg_high,
                                 input logic dig_high, input logic [3:0] digits);
        write_register(CFG_SCAN_BY_SEGMENT, {3'b000, by_segment});
        write_register(CFG_SEG_ACTIVE_HIGH, {3'b000, seg_high});
        write_register(CFG_DIG_ACTIVE_HIGH, {3'b000, dig_high});
        write_register(CFG_NUM_DIGITS, digits);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setting_total++;
    endtask

    // ------------------------------------------------------------------
    // Request driver. Valid is raised only when the slot is free and held
    // with a stable payload until the block takes it. After a request is
    // handed over, a random idle gap may follow.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                advance_display(bus_request);
                accepted_count++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    bus_request = pending_requests.pop_front();
                    i_mode     <= bus_request.mode;
                    i_value    <= bus_request.value;
                    i_comma    <= bus_request.comma;
                    i_position <= bus_request.position;
                    i_amount   <= bus_request.amount;
                    i_valid    <= 1'b1;
                    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                        send_gap = $urandom_range(17, 1);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor and consumer. Each response is checked against the
    // oldest expectation; ready drops in random bursts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_drives.size() == 0) begin
                    $error("response with no request outstanding: segment_drive 0x%02h, digit_drive 0x%02h",
                           o_segment_drive, o_digit_drive);
                    mismatch_count++;
                end else begin
                    oldest_drive = expected_drives.pop_front();
                    if (o_segment_drive !== oldest_drive.segment_drive) begin
                        $error("segment_drive: expected 0x%02h, actual 0x%02h",
                               oldest_drive.segment_drive, o_segment_drive);
                        mismatch_count++;
                    end
                    if (o_digit_drive !== oldest_drive.digit_drive) begin
                        $error("digit_drive: expected 0x%02h, actual 0x%02h",
                               oldest_drive.digit_drive, o_digit_drive);
                        mismatch_count++;
                    end
                    checked_count++;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
                recv_stall = $urandom_range(17, 1) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run stopped at the cycle limit with %0d of %0d responses checked",
                   checked_count, queued_count);
            $display("seven_segment_mux_driver_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence: directed requests at the reset setting, then
    // random phases, each under its own register setting and idle rates.
    // Every phase boundary lets the pipeline drain completely, which also
    // holds the sender off until every expected response is back.
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          j;
        logic        by_segment;
        logic        seg_high;
        logic        dig_high;
        logic [3:0]  digits;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: digit scan over four digits, both groups active high.
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        queue_request(MODE_TICK,   16'd0,     4'd0,  4'd0, 4'd0); // buffer still dark
        queue_request(MODE_VALUE,  16'd0,     4'd0,  4'd0, 4'd0); // lone zero, rest blank
        queue_request(MODE_TICK,   16'd0,     4'd0,  4'd0, 4'd0);
        queue_request(MODE_TICK,   16'd0,     4'd0,  4'd0, 4'd0);
        queue_request(MODE_VALUE,  16'hFFFF,  4'd0,  4'd0, 4'd0); // wider than the display
        queue_request(MODE_VALUE,  16'd7,     4'd3,  4'd0, 4'd0); // zeros kept up to the point
        queue_request(MODE_VALUE,  16'd12,    4'd15, 4'd0, 4'd0); // point past the last digit
        queue_request(MODE_VALUE,  16'd5,     4'd4,  4'd0, 4'd0); // point on the last digit
        queue_request(MODE_TICK,   16'd0,     4'd0,  4'd0, 4'd0);
        queue_request(MODE_FORMAT, 16'hFFFF,  4'd0,  4'd1, 4'd8); // run cut at the last digit
        queue_request(MODE_FORMAT, 16'd0,     4'd0,  4'd2, 4'd3); // zero then blanks
        queue_request(MODE_FORMAT, 16'd9,     4'd0,  4'd0, 4'd8); // position zero writes nothing
        queue_request(MODE_FORMAT, 16'd42,    4'd1,  4'd8, 4'd2); // position past count, point only
        queue_request(MODE_FORMAT, 16'd3,     4'd4,  4'd3, 4'd0); // amount zero, point only
        queue_request(MODE_FORMAT, 16'd1,     4'd3,  4'd2, 4'd2); // zero kept below the point
        for (j = 0; j < 6; j++) begin
            queue_request(MODE_TICK, 16'hFFFF, 4'hF, 4'd8, 4'd8); // scan wraps at four
        end
        wait_for_drain();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: {by_segment, seg_high, dig_high, digits} = {3'b111, 4'd8};
                1: {by_segment, seg_high, dig_high, digits} = {3'b000, 4'd1};
                2: {by_segment, seg_high, dig_high, digits} = {3'b101, 4'd3};
                3: {by_segment, seg_high, dig_high, digits} = {3'b010, 4'd8};
                4: {by_segment, seg_high, dig_high, digits} = {3'b110, 4'd1};
                7: {by_segment, seg_high, dig_high, digits} = {3'b011, 4'd5};
                default: begin
                    by_segment = 1'($urandom_range(1));
                    seg_high   = 1'($urandom_range(1));
                    dig_high   = 1'($urandom_range(1));
                    digits     = 4'($urandom_range(8, 1));
                end
            endcase
            // The final phase runs with no idling on either side.
            if (phase == PHASE_COUNT - 1) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                send_idle_pct  = (phase % 3 == 1) ? 0 : $urandom_range(30, 3);
                recv_stall_pct = (phase % 3 == 2) ? 0 : $urandom_range(30, 3);
            end
            apply_setting(by_segment, seg_high, dig_high, digits);
            // In the final phase any burst left over from the previous phase ends here.
            if (phase == PHASE_COUNT - 1) begin
                send_gap   = 0;
                recv_stall = 0;
            end
            for (j = 0; j < PHASE_REQUESTS; j++) queue_random_request();
            wait_for_drain();
        end

        // Let the pipeline settle so a stray extra response would be seen.
        repeat (6) @(posedge i_clk);

        $display("Covered %0d requests: %0d scan ticks, %0d value writes, %0d formatted writes,",
                 accepted_count, tick_total, value_total, format_total);
        $display("across %0d register settings in both scan styles and all line polarities.",
                 setting_total);
        if (mismatch_count == 0 && expected_drives.size() == 0) begin
            $display("seven_segment_mux_driver_core: match");
        end else begin
            $display("seven_segment_mux_driver_core: mismatch");
        end
        $finish;
    end

endmodule
